// File: src/tdh_pkg.sv
// Shared constants, codes and types of the timer deadline heap.
package tdh_pkg;

  // Heap capacity and the widths that follow from it.
  localparam int HEAP_DEPTH = 32;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int LR_W       = IDX_W + 2;

  // Fixed field widths.
  localparam int OP_W   = 1;
  localparam int ID_W   = 8;
  localparam int TIME_W = 63;
  localparam int PER_W  = 48;
  localparam int KIND_W = 3;

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(HEAP_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
  localparam logic [LR_W-1:0]   LR_ONE    = LR_W'(1);
  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OP_W-1:0] OP_CHECK  = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;

  // One heap slot.
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [PER_W-1:0]  period;
    logic [ID_W-1:0]   event_id;
  } entry_t;

  // Access to the heap store: one write port, two read ports.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } mem_req_t;

  // Operands of the shared adder: a + b, or a - b when sub is set.
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

endpackage

// File: src/tdh_if.sv
// Handshake channels of the timer deadline heap: input words and result words.
interface tdh_in_if;
  logic                       valid;
  logic                       ready;
  logic [tdh_pkg::OP_W-1:0]   op;
  logic [tdh_pkg::ID_W-1:0]   event_id;
  logic [tdh_pkg::TIME_W-1:0] deadline;
  logic [tdh_pkg::PER_W-1:0]  period;
  logic [tdh_pkg::TIME_W-1:0] now;

  modport source (output valid, op, event_id, deadline, period, now, input ready);
  modport sink (input valid, op, event_id, deadline, period, now, output ready);
endinterface

interface tdh_out_if;
  logic                       valid;
  logic                       ready;
  logic [tdh_pkg::KIND_W-1:0] kind;
  logic [tdh_pkg::ID_W-1:0]   fired_id;
  logic [tdh_pkg::TIME_W-1:0] delay;
  logic                       last;

  modport source (output valid, kind, fired_id, delay, last, input ready);
  modport sink (input valid, kind, fired_id, delay, last, output ready);
endinterface

// File: src/tdh_store.sv
// Heap slot memory: one write port and two read ports with registered read data.
module tdh_store (
  input  logic              clk,
  input  tdh_pkg::mem_req_t req,
  output tdh_pkg::entry_t   rdata_a_r,
  output tdh_pkg::entry_t   rdata_b_r
);

  tdh_pkg::entry_t mem [tdh_pkg::HEAP_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    // Read data holds while no read is issued.
    if (req.re) begin
      rdata_a_r <= mem[req.raddr_a];
      rdata_b_r <= mem[req.raddr_b];
    end
  end

endmodule

// File: src/tdh_alu.sv
// Shared adder and subtractor for all deadline compares and time arithmetic.
module tdh_alu (
  input  tdh_pkg::alu_req_t           req,
  output logic [tdh_pkg::TIME_W-1:0] res,
  output logic                        carry
);

  logic [tdh_pkg::TIME_W-1:0] b_op;
  logic [tdh_pkg::TIME_W:0]   sum;

  // For a subtraction the carry out is set exactly when a >= b.
  // For an addition it flags a sum past the time range.
  assign b_op  = req.sub ? ~req.b : req.b;
  assign sum   = {1'b0, req.a} + {1'b0, b_op} + {{tdh_pkg::TIME_W{1'b0}}, req.sub};
  assign res   = sum[tdh_pkg::TIME_W-1:0];
  assign carry = sum[tdh_pkg::TIME_W];

endmodule

// File: src/timer_deadline_heap_unit.sv
// Steps: an insert reads and compares one parent per level climbed, then writes the new event where it stops.
// A check reads the root for each look; per fired event it re-arms or refills the root, then sifts down with
// a read, a pick and a compare per level; a wait word passes through S_CHK_WAIT for the remaining time.
// Words are handled one at a time; the next word is taken once the sequencer is back in idle.
// Reset: the entry count clears to empty and the sequencer idles; the slot memory is not cleared.
module timer_deadline_heap_unit (
  input  logic        clk,
  input  logic        rst_n,
  tdh_in_if.sink      in_ch,
  tdh_out_if.source   out_ch
);

  // The sequencer walks the heap one level at a time. Every deadline compare and every
  // piece of time arithmetic goes through the single shared adder in tdh_alu; the heap
  // slots live in tdh_store. The element being sifted is held in cur_r and is written
  // only where it finally settles ("hole" sifting), which gives the same heap as swapping.
  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_FULL     = 14'b00000000000010,
    S_SU_RD    = 14'b00000000000100,
    S_SU_CMP   = 14'b00000000001000,
    S_INS_DONE = 14'b00000000010000,
    S_CHK_RD   = 14'b00000000100000,
    S_CHK_EV   = 14'b00000001000000,
    S_CHK_WAIT = 14'b00000010000000,
    S_REARM    = 14'b00000100000000,
    S_LAST_RD  = 14'b00001000000000,
    S_LAST_EV  = 14'b00010000000000,
    S_SD_RD    = 14'b00100000000000,
    S_SD_PICK  = 14'b01000000000000,
    S_SD_CMP   = 14'b10000000000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [tdh_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [tdh_pkg::CNT_W-1:0]    fires_r, fires_nxt;
  logic [tdh_pkg::IDX_W-1:0]    pos_r, pos_nxt;
  logic                         pick_right_r, pick_right_nxt;
  logic [tdh_pkg::TIME_W-1:0]   now_r, now_nxt;
  tdh_pkg::entry_t              cur_r, cur_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [tdh_pkg::KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [tdh_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [tdh_pkg::TIME_W-1:0]   out_delay_r, out_delay_nxt;
  logic                         out_last_r, out_last_nxt;

  tdh_pkg::mem_req_t            mem_req;
  tdh_pkg::entry_t              rdata_a_r, rdata_b_r;
  tdh_pkg::alu_req_t            alu_req;
  logic [tdh_pkg::TIME_W-1:0]   alu_res;
  logic                         alu_carry;

  logic                         slot_free;
  logic                         emit;
  logic [tdh_pkg::KIND_W-1:0]   emit_kind;
  logic [tdh_pkg::ID_W-1:0]     emit_id;
  logic [tdh_pkg::TIME_W-1:0]   emit_delay;
  logic                         emit_last;

  logic [tdh_pkg::LR_W-1:0]     left_idx, right_idx, pick_idx, count_ext;
  logic                         left_ok, right_ok;
  logic [tdh_pkg::IDX_W-1:0]    parent_idx;
  tdh_pkg::entry_t              pick_entry;

  tdh_store u_store (
    .clk       (clk),
    .req       (mem_req),
    .rdata_a_r (rdata_a_r),
    .rdata_b_r (rdata_b_r)
  );

  tdh_alu u_alu (
    .req   (alu_req),
    .res   (alu_res),
    .carry (alu_carry)
  );

  // Heap index arithmetic around the current position.
  assign count_ext  = {{(tdh_pkg::LR_W - tdh_pkg::CNT_W){1'b0}}, count_r};
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + tdh_pkg::LR_ONE;
  assign left_ok    = left_idx < count_ext;
  assign right_ok   = right_idx < count_ext;
  assign parent_idx = (pos_r - tdh_pkg::IDX_ONE) >> 1;
  assign pick_idx   = pick_right_r ? right_idx : left_idx;
  assign pick_entry = pick_right_r ? rdata_b_r : rdata_a_r;

  // The output register frees up in the same cycle its word is taken.
  assign slot_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.delay    = out_delay_r;
  assign out_ch.last     = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fires_nxt      = fires_r;
    pos_nxt        = pos_r;
    pick_right_nxt = pick_right_r;
    now_nxt        = now_r;
    cur_nxt        = cur_r;

    mem_req = '0;

    // By default the adder computes now minus the root deadline read last.
    alu_req.a   = now_r;
    alu_req.b   = rdata_a_r.deadline;
    alu_req.sub = 1'b1;

    emit       = 1'b0;
    emit_kind  = tdh_pkg::KIND_WAIT;
    emit_id    = '0;
    emit_delay = '0;
    emit_last  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.op == tdh_pkg::OP_INSERT) begin
            cur_nxt.deadline = in_ch.deadline;
            cur_nxt.period   = in_ch.period;
            cur_nxt.event_id = in_ch.event_id;
            pos_nxt          = count_r[tdh_pkg::IDX_W-1:0];
            state_nxt = (count_r == tdh_pkg::DEPTH_CNT) ? S_FULL : S_SU_RD;
          end else begin
            now_nxt   = in_ch.now;
            fires_nxt = '0;
            state_nxt = S_CHK_RD;
          end
        end
      end

      S_FULL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = tdh_pkg::KIND_FULL;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // Sift up: fetch the parent, or settle at the root.
      S_SU_RD: begin
        if (pos_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = cur_r;
          state_nxt     = S_INS_DONE;
        end else begin
          mem_req.re      = 1'b1;
          mem_req.raddr_a = parent_idx;
          state_nxt       = S_SU_CMP;
        end
      end

      // A parent strictly earlier stops the climb; on a tie the new event moves up.
      S_SU_CMP: begin
        alu_req.a   = rdata_a_r.deadline;
        alu_req.b   = cur_r.deadline;
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        if (!alu_carry) begin
          mem_req.wdata = cur_r;
          state_nxt     = S_INS_DONE;
        end else begin
          mem_req.wdata = rdata_a_r;
          pos_nxt       = parent_idx;
          state_nxt     = S_SU_RD;
        end
      end

      S_INS_DONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = tdh_pkg::KIND_INSERTED;
          emit_last = 1'b1;
          count_nxt = count_r + tdh_pkg::CNT_ONE;
          state_nxt = S_IDLE;
        end
      end

      S_CHK_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = S_CHK_EV;
      end

      // Root is in rdata_a_r; the adder gives lateness and, by its carry, whether it is due.
      S_CHK_EV: begin
        if (count_r == '0) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = tdh_pkg::KIND_EMPTY;
            emit_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!alu_carry) begin
          state_nxt = S_CHK_WAIT;
        end else if (fires_r == tdh_pkg::DEPTH_CNT) begin
          // Firing limit reached with the root still due: the wait is zero.
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = tdh_pkg::KIND_WAIT;
            emit_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = tdh_pkg::KIND_FIRED;
          emit_id    = rdata_a_r.event_id;
          emit_delay = alu_res;
          fires_nxt  = fires_r + tdh_pkg::CNT_ONE;
          if (rdata_a_r.period != '0) begin
            state_nxt = S_REARM;
          end else begin
            count_nxt = count_r - tdh_pkg::CNT_ONE;
            state_nxt = (count_r == tdh_pkg::CNT_ONE) ? S_CHK_RD : S_LAST_RD;
          end
        end
      end

      S_CHK_WAIT: begin
        alu_req.a = rdata_a_r.deadline;
        alu_req.b = now_r;
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = tdh_pkg::KIND_WAIT;
          emit_delay = alu_res;
          emit_last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // Periodic root: new deadline is now plus period, saturated at the top of the range.
      S_REARM: begin
        alu_req.b   = {{(tdh_pkg::TIME_W - tdh_pkg::PER_W){1'b0}}, rdata_a_r.period};
        alu_req.sub = 1'b0;
        cur_nxt.deadline = alu_carry ? tdh_pkg::TIME_MAX : alu_res;
        cur_nxt.period   = rdata_a_r.period;
        cur_nxt.event_id = rdata_a_r.event_id;
        pos_nxt          = '0;
        state_nxt        = S_SD_RD;
      end

      // One-shot root popped: the last entry moves to the root.
      S_LAST_RD: begin
        mem_req.re      = 1'b1;
        mem_req.raddr_a = count_r[tdh_pkg::IDX_W-1:0];
        state_nxt       = S_LAST_EV;
      end

      S_LAST_EV: begin
        cur_nxt   = rdata_a_r;
        pos_nxt   = '0;
        state_nxt = S_SD_RD;
      end

      // Sift down: fetch both children, or settle when there is none.
      S_SD_RD: begin
        if (!left_ok) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = cur_r;
          state_nxt     = S_CHK_RD;
        end else begin
          mem_req.re      = 1'b1;
          mem_req.raddr_a = left_idx[tdh_pkg::IDX_W-1:0];
          mem_req.raddr_b = right_ok ? right_idx[tdh_pkg::IDX_W-1:0]
                                     : left_idx[tdh_pkg::IDX_W-1:0];
          state_nxt       = S_SD_PICK;
        end
      end

      // The right child is taken only when it exists and is strictly earlier.
      S_SD_PICK: begin
        alu_req.a      = rdata_b_r.deadline;
        alu_req.b      = rdata_a_r.deadline;
        pick_right_nxt = right_ok && !alu_carry;
        state_nxt      = S_SD_CMP;
      end

      // A strictly earlier element stays put; otherwise the picked child moves up.
      S_SD_CMP: begin
        alu_req.a     = cur_r.deadline;
        alu_req.b     = pick_entry.deadline;
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        if (!alu_carry) begin
          mem_req.wdata = cur_r;
          state_nxt     = S_CHK_RD;
        end else begin
          mem_req.wdata = pick_entry;
          pos_nxt       = pick_idx[tdh_pkg::IDX_W-1:0];
          state_nxt     = S_SD_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded when a word is produced, held until taken.
  always_comb begin
    out_valid_nxt = emit || (out_valid_r && !out_ch.ready);
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_delay_nxt = out_delay_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_kind_nxt  = emit_kind;
      out_id_nxt    = emit_id;
      out_delay_nxt = emit_delay;
      out_last_nxt  = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fires_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fires_r     <= fires_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    pick_right_r <= pick_right_nxt;
    now_r        <= now_nxt;
    cur_r        <= cur_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_delay_r  <= out_delay_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
